/* hw/rtl/rsh_pkg.sv */
// Shared types and constants for the rollback statistics histogram block.
// No dependencies; every other file in hw/rtl imports this package.
`default_nettype none

package rsh_pkg;

   localparam int FRAME_W   = 32;
   localparam int DIST_W    = 8;
   localparam int FLAGS_W   = 8;
   localparam int CNT_W     = 32;
   localparam int SUM_W     = 40;
   localparam int IDX_OUT_W = 3;

   // Upper bounds of the histogram buckets, entry 0 first.
   localparam int BOUND_COUNT = 9;
   localparam logic [BOUND_COUNT-1:0][DIST_W-1:0] BUCKET_BOUND = {
      8'd128, 8'd64, 8'd32, 8'd16, 8'd8, 8'd4, 8'd2, 8'd1, 8'd0
   };

   localparam logic RESULT_EVENT  = 1'b0;
   localparam logic RESULT_BUCKET = 1'b1;

   typedef struct packed {
      logic [FRAME_W-1:0] record_frame;
      logic [DIST_W-1:0]  rollback_distance;
      logic [FLAGS_W-1:0] record_flags;
      logic               end_of_replay;
   } rsh_req_type;

   // Update strobe shared by the statistics and histogram units.
   typedef struct packed {
      logic              fire;
      logic              clear;
      logic [DIST_W-1:0] distance;
   } rsh_upd_type;

   typedef struct packed {
      logic [CNT_W-1:0]  seen_count;
      logic [CNT_W-1:0]  rollback_count;
      logic [SUM_W-1:0]  rollback_sum;
      logic [DIST_W-1:0] rollback_peak;
      logic [CNT_W-1:0]  desync_count;
   } rsh_stats_type;

   typedef struct packed {
      logic                 result_kind;
      logic [FRAME_W-1:0]   event_frame;
      logic [DIST_W-1:0]    event_distance;
      logic                 event_desync;
      logic [IDX_OUT_W-1:0] bucket_index;
      logic [CNT_W-1:0]     bucket_total;
      rsh_stats_type        stats;
      logic                 last_of_run;
   } rsh_rsp_type;

endpackage

`default_nettype wire

/* hw/rtl/rollback_stats_histogram_core.sv */
// Top level of the rollback statistics histogram block.
// Depends on rsh_pkg, rsh_stats and rsh_hist.
//
// Usage:
//  - req_* channel: one replay record per transaction (valid/stall). A record
//    enters an input register, and is processed the next cycle it can go: the
//    statistics and histogram update, and an event result (nonzero rollback or
//    desync) lands in the output register.
//  - rsp_* channel: one result per transaction, held in a single output
//    register; rsp_last_of_run marks the last result of a record.
//  - A record passes the input register, then its result the output register.
//  - Throughput: one record per cycle when not stalled. A record with
//    end_of_replay set then dumps BUCKET_COUNT reports from the histogram
//    read mux, one per cycle while rsp_stall is low; a waiting record stalls
//    during the dump, and all statistics clear as the last report is loaded.
//  - csr_wr_en / csr_wr_data write the desync flag mask (reset value 1);
//    write only while the block is idle.
//  - Reset (synchronous) empties both registers, clears all statistics and
//    buckets, and sets the mask to 1. No clearing pass is needed.
//  - When rsp_stall is high with rsp_valid set, the output register holds; the
//    input register waits and req_stall rises, so nothing is dropped.
`default_nettype none

module rollback_stats_histogram_core #(
   parameter int BUCKET_COUNT = 8
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   // configuration
   input  wire logic                     csr_wr_en,
   input  wire logic [rsh_pkg::FLAGS_W-1:0] csr_wr_data,
   // record channel
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [rsh_pkg::FRAME_W-1:0] req_record_frame,
   input  wire logic [rsh_pkg::DIST_W-1:0]  req_rollback_distance,
   input  wire logic [rsh_pkg::FLAGS_W-1:0] req_record_flags,
   input  wire logic                     req_end_of_replay,
   // result channel
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic                          rsp_result_kind,
   output logic [rsh_pkg::FRAME_W-1:0]   rsp_event_frame,
   output logic [rsh_pkg::DIST_W-1:0]    rsp_event_distance,
   output logic                          rsp_event_desync,
   output logic [rsh_pkg::IDX_OUT_W-1:0] rsp_bucket_index,
   output logic [rsh_pkg::CNT_W-1:0]     rsp_bucket_total,
   output logic [rsh_pkg::CNT_W-1:0]     rsp_frames_seen,
   output logic [rsh_pkg::CNT_W-1:0]     rsp_rollback_events,
   output logic [rsh_pkg::SUM_W-1:0]     rsp_rollback_frames_sum,
   output logic [rsh_pkg::DIST_W-1:0]    rsp_largest_rollback,
   output logic [rsh_pkg::CNT_W-1:0]     rsp_desync_events,
   output logic                          rsp_last_of_run
);
   import rsh_pkg::*;

   localparam int IDX_W = $clog2(BUCKET_COUNT);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUCKET_COUNT - 1);

   logic [FLAGS_W-1:0] mask_ff;
   logic               in_valid_ff;
   rsh_req_type        in_ff;
   logic               dump_ff;
   logic [IDX_W-1:0]   dump_idx_ff;
   logic               rsp_valid_ff;
   rsh_rsp_type        rsp_ff;
   rsh_rsp_type        rsp_in;

   logic               req_accept;
   logic               out_free;
   logic               fire;
   logic               dump_step;
   logic               dump_done;
   logic               desync;
   logic               is_event;
   rsh_upd_type        upd;
   rsh_stats_type      stats_cur;
   rsh_stats_type      stats_nxt;
   logic [CNT_W-1:0]   bucket_rd;

   // handshake
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign fire       = in_valid_ff && !dump_ff && out_free;
   assign dump_step  = dump_ff && out_free;
   assign dump_done  = dump_step && (dump_idx_ff == LAST_IDX);
   assign req_stall  = in_valid_ff && !fire;
   assign req_accept = req_valid && !req_stall;

   assign desync   = |(in_ff.record_flags & mask_ff);
   assign is_event = (in_ff.rollback_distance != '0) || desync;

   assign upd.fire     = fire;
   assign upd.clear    = dump_done;
   assign upd.distance = in_ff.rollback_distance;

   rsh_stats u_stats (
      .clock  (clock),
      .reset  (reset),
      .upd    (upd),
      .desync (desync),
      .cur    (stats_cur),
      .nxt    (stats_nxt)
   );

   rsh_hist #(
      .BUCKET_COUNT (BUCKET_COUNT)
   ) u_hist (
      .clock    (clock),
      .reset    (reset),
      .upd      (upd),
      .rd_idx   (dump_idx_ff),
      .rd_total (bucket_rd)
   );

   // result select: event from the record in flight, or the next bucket report
   always_comb begin
      rsp_in = '0;
      if (dump_ff) begin
         rsp_in.result_kind  = RESULT_BUCKET;
         rsp_in.bucket_index = IDX_OUT_W'(dump_idx_ff);
         rsp_in.bucket_total = bucket_rd;
         rsp_in.stats        = stats_cur;
         rsp_in.last_of_run  = (dump_idx_ff == LAST_IDX);
      end else begin
         rsp_in.result_kind    = RESULT_EVENT;
         rsp_in.event_frame    = in_ff.record_frame;
         rsp_in.event_distance = in_ff.rollback_distance;
         rsp_in.event_desync   = desync;
         rsp_in.stats          = stats_nxt;
         rsp_in.last_of_run    = !in_ff.end_of_replay;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= FLAGS_W'(1);
         in_valid_ff  <= 1'b0;
         dump_ff      <= 1'b0;
         dump_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) mask_ff <= csr_wr_data;

         if (req_accept) begin
            in_valid_ff <= 1'b1;
         end else if (fire) begin
            in_valid_ff <= 1'b0;
         end

         if (fire && in_ff.end_of_replay) begin
            dump_ff <= 1'b1;
         end else if (dump_done) begin
            dump_ff <= 1'b0;
         end

         if (fire) begin
            dump_idx_ff <= '0;
         end else if (dump_step) begin
            dump_idx_ff <= dump_done ? '0 : dump_idx_ff + 1'b1;
         end

         if ((fire && is_event) || dump_step) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_ff.record_frame      <= req_record_frame;
         in_ff.rollback_distance <= req_rollback_distance;
         in_ff.record_flags      <= req_record_flags;
         in_ff.end_of_replay     <= req_end_of_replay;
      end
      if ((fire && is_event) || dump_step) rsp_ff <= rsp_in;
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_result_kind         = rsp_ff.result_kind;
   assign rsp_event_frame         = rsp_ff.event_frame;
   assign rsp_event_distance      = rsp_ff.event_distance;
   assign rsp_event_desync        = rsp_ff.event_desync;
   assign rsp_bucket_index        = rsp_ff.bucket_index;
   assign rsp_bucket_total        = rsp_ff.bucket_total;
   assign rsp_frames_seen         = rsp_ff.stats.seen_count;
   assign rsp_rollback_events     = rsp_ff.stats.rollback_count;
   assign rsp_rollback_frames_sum = rsp_ff.stats.rollback_sum;
   assign rsp_largest_rollback    = rsp_ff.stats.rollback_peak;
   assign rsp_desync_events       = rsp_ff.stats.desync_count;
   assign rsp_last_of_run         = rsp_ff.last_of_run;

endmodule

`default_nettype wire

/* hw/rtl/rsh_stats.sv */
// Running rollback statistics: saturating counters, saturating sum, peak.
// Depends on rsh_pkg.
`default_nettype none

module rsh_stats (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire rsh_pkg::rsh_upd_type upd,
   input  wire logic                desync,
   output rsh_pkg::rsh_stats_type   cur,
   output rsh_pkg::rsh_stats_type   nxt
);
   import rsh_pkg::*;

   rsh_stats_type     stats_ff;
   logic [SUM_W:0]    sum_wide;
   logic              rollback;

   assign cur      = stats_ff;
   assign rollback = (upd.distance != '0);
   assign sum_wide = {1'b0, stats_ff.rollback_sum}
                   + {{(SUM_W + 1 - DIST_W){1'b0}}, upd.distance};

   // Values including the record in flight.
   always_comb begin
      nxt = stats_ff;
      if (stats_ff.seen_count != '1) nxt.seen_count = stats_ff.seen_count + 1'b1;
      if (rollback) begin
         if (stats_ff.rollback_count != '1) begin
            nxt.rollback_count = stats_ff.rollback_count + 1'b1;
         end
         nxt.rollback_sum = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
         if (upd.distance > stats_ff.rollback_peak) nxt.rollback_peak = upd.distance;
      end
      if (desync && stats_ff.desync_count != '1) begin
         nxt.desync_count = stats_ff.desync_count + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || upd.clear) begin
         stats_ff <= '0;
      end else if (upd.fire) begin
         stats_ff <= nxt;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/rsh_hist.sv */
// Histogram of rollback distances: bucket select, saturating bucket counters
// and the read mux used by the end-of-replay dump. Depends on rsh_pkg.
`default_nettype none

module rsh_hist #(
   parameter int BUCKET_COUNT = 8,
   localparam int IDX_W = $clog2(BUCKET_COUNT)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire rsh_pkg::rsh_upd_type upd,
   input  wire logic [IDX_W-1:0]     rd_idx,
   output logic [rsh_pkg::CNT_W-1:0] rd_total
);
   import rsh_pkg::*;

   logic [CNT_W-1:0] counts_ff [BUCKET_COUNT];
   logic [IDX_W-1:0] pick;

   // Lowest bucket whose bound covers the distance; the last takes the rest.
   always_comb begin
      pick = IDX_W'(BUCKET_COUNT - 1);
      for (int i = BUCKET_COUNT - 2; i >= 0; i--) begin
         if (upd.distance <= BUCKET_BOUND[i]) pick = IDX_W'(i);
      end
   end

   assign rd_total = counts_ff[rd_idx];

   always_ff @(posedge clock) begin
      if (reset || upd.clear) begin
         for (int i = 0; i < BUCKET_COUNT; i++) counts_ff[i] <= '0;
      end else if (upd.fire && counts_ff[pick] != '1) begin
         counts_ff[pick] <= counts_ff[pick] + 1'b1;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/rsh_checker.sv */
// Port-level assertions for rollback_stats_histogram_core, plus the bind.
// Depends on rsh_pkg for field widths.
`default_nettype none

module rsh_checker (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_stall,
   input wire logic                     rsp_result_kind,
   input wire logic [rsh_pkg::DIST_W-1:0]    rsp_event_distance,
   input wire logic                     rsp_event_desync,
   input wire logic [rsh_pkg::IDX_OUT_W-1:0] rsp_bucket_index,
   input wire logic [rsh_pkg::CNT_W-1:0]     rsp_bucket_total,
   input wire logic [rsh_pkg::CNT_W-1:0]     rsp_frames_seen,
   input wire logic [rsh_pkg::CNT_W-1:0]     rsp_rollback_events,
   input wire logic [rsh_pkg::DIST_W-1:0]    rsp_largest_rollback,
   input wire logic [rsh_pkg::CNT_W-1:0]     rsp_desync_events
);
   import rsh_pkg::*;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_frames_seen)
         && $stable(rsp_result_kind) && $stable(rsp_bucket_total))
      else $error("result changed while stalled");

   // an event only comes from a rollback or a desync record
   a_event_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == RESULT_EVENT
         |-> rsp_event_distance != '0 || rsp_event_desync)
      else $error("event without rollback or desync");

   a_event_no_bucket: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == RESULT_EVENT
         |-> rsp_bucket_index == '0 && rsp_bucket_total == '0
            && rsp_event_distance <= rsp_largest_rollback)
      else $error("event carries bucket data or exceeds peak");

   // subcounts never pass the record count
   a_counts_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_rollback_events <= rsp_frames_seen
         && rsp_desync_events <= rsp_frames_seen)
      else $error("subcount above record count");

endmodule

bind rollback_stats_histogram_core rsh_checker u_rsh_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_result_kind      (rsp_result_kind),
   .rsp_event_distance   (rsp_event_distance),
   .rsp_event_desync     (rsp_event_desync),
   .rsp_bucket_index     (rsp_bucket_index),
   .rsp_bucket_total     (rsp_bucket_total),
   .rsp_frames_seen      (rsp_frames_seen),
   .rsp_rollback_events  (rsp_rollback_events),
   .rsp_largest_rollback (rsp_largest_rollback),
   .rsp_desync_events    (rsp_desync_events)
);

`default_nettype wire

/* test/rollback_stats_histogram_core_test.sv */
// Testbench for rollback_stats_histogram_core: a directed table, then random replays
// checked against a local model of the statistics and the histogram.
// Depends on rsh_pkg and the core RTL only.
`timescale 1ns / 100ps

module rollback_stats_histogram_core_test;
   import rsh_pkg::*;

   localparam int HIST_BINS = 8;
   localparam int CYCLE_LIMIT = 200000;
   // settle time after the last result: input and output registers plus
   // margin for a plain record still in flight
   localparam int SETTLE_CYCLES = 6;
   localparam logic [CNT_W-1:0] CNT_MAX = '1;
   localparam logic [SUM_W-1:0] SUM_MAX = '1;
   // upper bound of each histogram bin below the last; the last takes the rest
   localparam logic [HIST_BINS-2:0][DIST_W-1:0] BIN_LIMIT = {
      8'd32, 8'd16, 8'd8, 8'd4, 8'd2, 8'd1, 8'd0
   };

   // how a directed row is checked
   typedef enum logic [1:0] {
      ROW_PREDICT,   // expectations come from the local model
      ROW_QUIET,     // typed in: plain record, no transaction out
      ROW_EVENT      // typed in: exactly one event transaction
   } row_check_type;

   typedef struct {
      row_check_type      check;
      logic [FRAME_W-1:0] frame;
      logic [DIST_W-1:0]  distance;
      logic [FLAGS_W-1:0] flags;
      logic               end_of_replay;
      logic               want_desync;
      logic [CNT_W-1:0]   want_seen;
      logic [CNT_W-1:0]   want_rollbacks;
      logic [SUM_W-1:0]   want_sum;
      logic [DIST_W-1:0]  want_peak;
      logic [CNT_W-1:0]   want_desyncs;
   } directed_row_type;

   // ---------------------------------------------------------------------
   // DUT and its drivers; every input starts at a known value
   // ---------------------------------------------------------------------
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_wr_en = 1'b0;
   logic [FLAGS_W-1:0]   csr_wr_data = '0;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [FRAME_W-1:0]   req_record_frame = '0;
   logic [DIST_W-1:0]    req_rollback_distance = '0;
   logic [FLAGS_W-1:0]   req_record_flags = '0;
   logic                 req_end_of_replay = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic                 rsp_result_kind;
   logic [FRAME_W-1:0]   rsp_event_frame;
   logic [DIST_W-1:0]    rsp_event_distance;
   logic                 rsp_event_desync;
   logic [IDX_OUT_W-1:0] rsp_bucket_index;
   logic [CNT_W-1:0]     rsp_bucket_total;
   logic [CNT_W-1:0]     rsp_frames_seen;
   logic [CNT_W-1:0]     rsp_rollback_events;
   logic [SUM_W-1:0]     rsp_rollback_frames_sum;
   logic [DIST_W-1:0]    rsp_largest_rollback;
   logic [CNT_W-1:0]     rsp_desync_events;
   logic                 rsp_last_of_run;

   rollback_stats_histogram_core #(
      .BUCKET_COUNT(HIST_BINS)
   ) dut (
      .clock                  (clock),
      .reset                  (reset),
      .csr_wr_en              (csr_wr_en),
      .csr_wr_data            (csr_wr_data),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_record_frame       (req_record_frame),
      .req_rollback_distance  (req_rollback_distance),
      .req_record_flags       (req_record_flags),
      .req_end_of_replay      (req_end_of_replay),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_result_kind        (rsp_result_kind),
      .rsp_event_frame        (rsp_event_frame),
      .rsp_event_distance     (rsp_event_distance),
      .rsp_event_desync       (rsp_event_desync),
      .rsp_bucket_index       (rsp_bucket_index),
      .rsp_bucket_total       (rsp_bucket_total),
      .rsp_frames_seen        (rsp_frames_seen),
      .rsp_rollback_events    (rsp_rollback_events),
      .rsp_rollback_frames_sum(rsp_rollback_frames_sum),
      .rsp_largest_rollback   (rsp_largest_rollback),
      .rsp_desync_events      (rsp_desync_events),
      .rsp_last_of_run        (rsp_last_of_run)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Local model of the block: running statistics, histogram and the
   // desync mask, updated once per accepted record
   // ---------------------------------------------------------------------
   logic [FLAGS_W-1:0] desync_mask;
   logic [CNT_W-1:0]   tally_records;
   logic [CNT_W-1:0]   tally_rollbacks;
   logic [SUM_W-1:0]   tally_sum;
   logic [DIST_W-1:0]  tally_peak;
   logic [CNT_W-1:0]   tally_desyncs;
   logic [CNT_W-1:0]   hist_bins [HIST_BINS];

   // results owed by the block, oldest first
   rsh_rsp_type pending_results[$];
   // results of the record most recently run through the model
   rsh_rsp_type record_results[$];

   directed_row_type directed_rows[$];

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int failures = 0;
   int records_sent = 0;
   int results_checked = 0;
   int dumps_sent = 0;
   int cycle_count = 0;

   function automatic logic [CNT_W-1:0] sat_bump(input logic [CNT_W-1:0] v);
      return (v == CNT_MAX) ? v : v + 1'b1;
   endfunction

   function automatic int bin_for(input logic [DIST_W-1:0] distance);
      int i;
      for (i = 0; i < HIST_BINS - 1; i++) begin
         if (distance <= BIN_LIMIT[i]) return i;
      end
      return HIST_BINS - 1;
   endfunction

   function automatic void clear_tallies();
      tally_records = '0;
      tally_rollbacks = '0;
      tally_sum = '0;
      tally_peak = '0;
      tally_desyncs = '0;
      foreach (hist_bins[i]) hist_bins[i] = '0;
   endfunction

   function automatic rsh_stats_type current_stats();
      rsh_stats_type s;
      s.seen_count = tally_records;
      s.rollback_count = tally_rollbacks;
      s.rollback_sum = tally_sum;
      s.rollback_peak = tally_peak;
      s.desync_count = tally_desyncs;
      return s;
   endfunction

   // Update the model with one record and leave its results in record_results.
   function automatic void tally_record(input rsh_req_type r);
      rsh_rsp_type res;
      logic        is_desync;
      int          i;
      record_results.delete();
      is_desync = (r.record_flags & desync_mask) != '0;
      tally_records = sat_bump(tally_records);
      if (r.rollback_distance != '0) begin
         tally_rollbacks = sat_bump(tally_rollbacks);
         if (tally_sum > SUM_MAX - SUM_W'(r.rollback_distance)) tally_sum = SUM_MAX;
         else tally_sum = tally_sum + SUM_W'(r.rollback_distance);
         if (r.rollback_distance > tally_peak) tally_peak = r.rollback_distance;
      end
      if (is_desync) tally_desyncs = sat_bump(tally_desyncs);
      hist_bins[bin_for(r.rollback_distance)] = sat_bump(hist_bins[bin_for(r.rollback_distance)]);

      if (r.rollback_distance != '0 || is_desync) begin
         res = '0;
         res.result_kind = RESULT_EVENT;
         res.event_frame = r.record_frame;
         res.event_distance = r.rollback_distance;
         res.event_desync = is_desync;
         res.stats = current_stats();
         res.last_of_run = !r.end_of_replay;
         record_results = {record_results, res};
      end
      if (r.end_of_replay) begin
         // bin reports carry the final statistics, then everything clears
         for (i = 0; i < HIST_BINS; i++) begin
            res = '0;
            res.result_kind = RESULT_BUCKET;
            res.bucket_index = IDX_OUT_W'(i);
            res.bucket_total = hist_bins[i];
            res.stats = current_stats();
            res.last_of_run = (i == HIST_BINS - 1);
            record_results = {record_results, res};
         end
         clear_tallies();
      end
   endfunction

   // ---------------------------------------------------------------------
   // Record sender. Called at a rising edge; returns at the edge where the
   // transaction is accepted.
   // ---------------------------------------------------------------------
   task automatic idle_gap();
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic send_record(input rsh_req_type r, input row_check_type check,
                              input rsh_rsp_type typed);
      req_valid <= 1'b1;
      req_record_frame <= r.record_frame;
      req_rollback_distance <= r.rollback_distance;
      req_record_flags <= r.record_flags;
      req_end_of_replay <= r.end_of_replay;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      records_sent++;
      if (r.end_of_replay) dumps_sent++;
      // the model always advances; typed rows replace what it predicts
      tally_record(r);
      case (check)
         ROW_PREDICT: begin
            pending_results = {pending_results, record_results};
         end
         ROW_EVENT: pending_results = {pending_results, typed};
         default: ;
      endcase
   endtask

   // Let every owed result drain, then give a plain record time to clear.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mask(input logic [FLAGS_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      desync_mask = value;
   endtask

   // Random replays: mostly runs of consecutive frames ending in an end of
   // replay, with the odd frame jump as noise.
   task automatic run_replays(input int count);
      rsh_req_type        r;
      logic [FRAME_W-1:0] next_frame;
      int                 i;
      next_frame = $urandom;
      for (i = 0; i < count; i++) begin
         if ($urandom_range(19) == 0) next_frame = $urandom;
         r.record_frame = next_frame;
         next_frame = next_frame + 1'b1;
         case ($urandom_range(9)) inside
            [0:4]: r.rollback_distance = '0;
            [5:7]: r.rollback_distance = DIST_W'($urandom_range(40, 1));
            default: r.rollback_distance = DIST_W'($urandom_range(255, 0));
         endcase
         r.record_flags = ($urandom_range(3) == 0) ? '0 : FLAGS_W'($urandom);
         r.end_of_replay = (i == count - 1) || ($urandom_range(13) == 0);
         idle_gap();
         send_record(r, ROW_PREDICT, '0);
      end
   endtask

   function automatic void add_row(input directed_row_type row);
      directed_rows = {directed_rows, row};
   endfunction

   // Directed table, run with the reset mask (bit 0 marks desync).
   // Typed rows follow from the reset state at a glance.
   function automatic void load_directed_rows();
      // after reset: plain record, then first rollback and first desync
      add_row('{ROW_QUIET, 32'd0, 8'd0, 8'h00, 1'b0,
                1'b0, 32'd0, 32'd0, 40'd0, 8'd0, 32'd0});
      add_row('{ROW_EVENT, 32'd1, 8'd1, 8'h00, 1'b0,
                1'b0, 32'd2, 32'd1, 40'd1, 8'd1, 32'd0});
      add_row('{ROW_EVENT, 32'd2, 8'd0, 8'h01, 1'b0,
                1'b1, 32'd3, 32'd1, 40'd1, 8'd1, 32'd1});
      // all-ones frame, distance and flags
      add_row('{ROW_EVENT, 32'hFFFF_FFFF, 8'd255, 8'hFF, 1'b0,
                1'b1, 32'd4, 32'd2, 40'd256, 8'd255, 32'd2});
      // flags set only outside the mask: still a plain record
      add_row('{ROW_QUIET, 32'd5, 8'd0, 8'hFE, 1'b0,
                1'b0, 32'd0, 32'd0, 40'd0, 8'd0, 32'd0});
      // end of replay with no event: bin reports only
      add_row('{ROW_PREDICT, 32'd6, 8'd0, 8'h00, 1'b1,
                1'b0, 32'd0, 32'd0, 40'd0, 8'd0, 32'd0});
      // statistics start over after the dump
      add_row('{ROW_EVENT, 32'd7, 8'd2, 8'h00, 1'b0,
                1'b0, 32'd1, 32'd1, 40'd2, 8'd2, 32'd0});
      // walk every bin edge, on and just past each bound
      add_row('{ROW_PREDICT, 32'd8, 8'd3, 8'h80, 1'b0,
                1'b0, '0, '0, '0, '0, '0});
      add_row('{ROW_PREDICT, 32'd9, 8'd4, 8'h00, 1'b0,
                1'b0, '0, '0, '0, '0, '0});
      add_row('{ROW_PREDICT, 32'd10, 8'd5, 8'h01, 1'b0,
                1'b0, '0, '0, '0, '0, '0});
      add_row('{ROW_PREDICT, 32'd11, 8'd8, 8'h00, 1'b0,
                1'b0, '0, '0, '0, '0, '0});
      add_row('{ROW_PREDICT, 32'd12, 8'd9, 8'h00, 1'b0,
                1'b0, '0, '0, '0, '0, '0});
      add_row('{ROW_PREDICT, 32'd13, 8'd16, 8'h03, 1'b0,
                1'b0, '0, '0, '0, '0, '0});
      add_row('{ROW_PREDICT, 32'd14, 8'd17, 8'h00, 1'b0,
                1'b0, '0, '0, '0, '0, '0});
      add_row('{ROW_PREDICT, 32'd15, 8'd32, 8'h00, 1'b0,
                1'b0, '0, '0, '0, '0, '0});
      add_row('{ROW_PREDICT, 32'd16, 8'd33, 8'h00, 1'b0,
                1'b0, '0, '0, '0, '0, '0});
      add_row('{ROW_PREDICT, 32'd17, 8'd64, 8'h00, 1'b0,
                1'b0, '0, '0, '0, '0, '0});
      add_row('{ROW_PREDICT, 32'd18, 8'd65, 8'h00, 1'b0,
                1'b0, '0, '0, '0, '0, '0});
      add_row('{ROW_PREDICT, 32'd19, 8'd128, 8'h01, 1'b0,
                1'b0, '0, '0, '0, '0, '0});
      // end of replay with an event: event first, then the reports
      add_row('{ROW_PREDICT, 32'h8000_0000, 8'd7, 8'h03, 1'b1,
                1'b0, '0, '0, '0, '0, '0});
      // single-record replay
      add_row('{ROW_PREDICT, 32'd0, 8'd0, 8'h00, 1'b1,
                1'b0, '0, '0, '0, '0, '0});
   endfunction

   // ---------------------------------------------------------------------
   // Result side: random stall, and each accepted transaction checked
   // against the oldest owed result
   // ---------------------------------------------------------------------
   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin : result_monitor
      rsh_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $error("result transaction with nothing owed (kind %0b frame 0x%0h)",
                      rsp_result_kind, rsp_event_frame);
               failures++;
            end else begin
               want = pending_results.pop_front();
               results_checked++;
               check_field("result_kind", 64'(want.result_kind), 64'(rsp_result_kind));
               check_field("event_frame", 64'(want.event_frame), 64'(rsp_event_frame));
               check_field("event_distance", 64'(want.event_distance),
                           64'(rsp_event_distance));
               check_field("event_desync", 64'(want.event_desync), 64'(rsp_event_desync));
               check_field("bucket_index", 64'(want.bucket_index), 64'(rsp_bucket_index));
               check_field("bucket_total", 64'(want.bucket_total), 64'(rsp_bucket_total));
               check_field("frames_seen", 64'(want.stats.seen_count), 64'(rsp_frames_seen));
               check_field("rollback_events", 64'(want.stats.rollback_count),
                           64'(rsp_rollback_events));
               check_field("rollback_frames_sum", 64'(want.stats.rollback_sum),
                           64'(rsp_rollback_frames_sum));
               check_field("largest_rollback", 64'(want.stats.rollback_peak),
                           64'(rsp_largest_rollback));
               check_field("desync_events", 64'(want.stats.desync_count),
                           64'(rsp_desync_events));
               check_field("last_of_run", 64'(want.last_of_run), 64'(rsp_last_of_run));
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // watchdog: a hung handshake ends the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still owed",
                  cycle_count, pending_results.size());
         $display("rollback_stats_histogram_core test failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Sequence: directed table, then three random phases, each under its own
   // desync mask and idling pattern
   // ---------------------------------------------------------------------
   initial begin : stimulus
      rsh_req_type      r;
      rsh_rsp_type      typed;
      directed_row_type row;
      logic [FLAGS_W-1:0] mid_mask;

      desync_mask = 8'h01;
      clear_tallies();
      load_directed_rows();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 10;
      recv_stall_pct = 52;
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         r.record_frame = row.frame;
         r.rollback_distance = row.distance;
         r.record_flags = row.flags;
         r.end_of_replay = row.end_of_replay;
         typed = '0;
         typed.result_kind = RESULT_EVENT;
         typed.event_frame = row.frame;
         typed.event_distance = row.distance;
         typed.event_desync = row.want_desync;
         typed.stats.seen_count = row.want_seen;
         typed.stats.rollback_count = row.want_rollbacks;
         typed.stats.rollback_sum = row.want_sum;
         typed.stats.rollback_peak = row.want_peak;
         typed.stats.desync_count = row.want_desyncs;
         typed.last_of_run = 1'b1;
         idle_gap();
         send_record(r, row.check, typed);
      end

      // every flag bit marks desync
      wait_idle();
      write_mask(8'hFF);
      run_replays(70);

      // desync disabled; now the sender is the slow side
      wait_idle();
      write_mask(8'h00);
      send_idle_pct = 52;
      recv_stall_pct = 10;
      run_replays(70);

      // some mixed mask, full rate on both sides
      wait_idle();
      mid_mask = FLAGS_W'($urandom_range(254, 1));
      write_mask(mid_mask);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      run_replays(69);

      wait_idle();
      foreach (pending_results[i]) begin
         $error("owed result never arrived: kind %0b frame 0x%0h bin %0d",
                pending_results[i].result_kind, pending_results[i].event_frame,
                pending_results[i].bucket_index);
         failures++;
      end
      $display("%0d records in, %0d results checked, %0d histogram dumps",
               records_sent, results_checked, dumps_sent);
      $display("desync masks 0x01, 0xff, 0x00 and 0x%02h under three stall patterns",
               mid_mask);
      if (failures == 0) begin
         $display("rollback_stats_histogram_core test passed");
      end else begin
         $display("rollback_stats_histogram_core test failed");
      end
      $finish;
   end

endmodule

/* rollback_stats_histogram_core.f */
hw/rtl/rsh_pkg.sv
hw/rtl/rsh_stats.sv
hw/rtl/rsh_hist.sv
hw/rtl/rollback_stats_histogram_core.sv
hw/rtl/rsh_checker.sv
test/rollback_stats_histogram_core_test.sv
